FILE: design/ukat_pkg.sv
package ukat_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int CFG_W       = 7;
  localparam int FUNC_W      = 3;
  localparam int STAT_W      = 3;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd3;
  localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd5;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADIDX   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_ZERO     = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the request fields
    logic cmp;    // compare the key against every occupied cell
    logic find;   // encode the match vector into an index
    logic exec;   // apply the operation and load the result register
  } ukat_cmd_t;

endpackage

FILE: design/ukat_datapath.sv
module ukat_datapath
  import ukat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ukat_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_value,
  input  logic [FUNC_W-1:0]     func,
  input  logic [IDX_W-1:0]      position,
  input  logic [KEY_WIDTH-1:0]  key_value,
  output logic [STAT_W-1:0]     status,
  output logic [IDX_W-1:0]      found_index,
  output logic [KEY_WIDTH-1:0]  read_key,
  output logic [CNT_W-1:0]      entries_used
);

  // Request registers and table state.
  logic [FUNC_W-1:0]    func_r;
  logic [IDX_W-1:0]     pos_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CFG_W-1:0]     cap_limit;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [KEY_WIDTH-1:0] slots [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;

  // Combinational decision for the current request.
  logic [CNT_W-1:0]     eff_limit;
  logic [CNT_W-1:0]     pos_x;
  logic                 full;
  logic                 key_zero;
  logic                 do_app;
  logic                 do_del;
  logic                 do_ins;
  logic                 do_upd;
  logic [STAT_W-1:0]    st;
  logic [IDX_W-1:0]     fidx;
  logic [KEY_WIDTH-1:0] rkey;
  logic [KEY_WIDTH-1:0] pos_key;
  logic [TABLE_DEPTH-1:0] match_next;
  logic                 hit_next;
  logic [IDX_W-1:0]     hit_idx_next;

  // Capacity register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CFG_W'(TABLE_DEPTH);
    end else if (cfg_we) begin
      cap_limit <= cfg_value;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      pos_r  <= position;
      key_r  <= key_value;
    end
  end

  // Every occupied cell compares its key in parallel.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_next[i] = (slots[i] == key_r) && (CNT_W'(i) < count);
    end
  end

  // Keys are unique, so at most one match bit is set and an OR encoder suffices.
  always_comb begin
    hit_next     = |match;
    hit_idx_next = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match[i]) begin
        hit_idx_next = hit_idx_next | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match   <= '0;
      hit     <= 1'b0;
      hit_idx <= '0;
    end else begin
      if (cmd.cmp) begin
        match <= match_next;
      end
      if (cmd.find) begin
        hit     <= hit_next;
        hit_idx <= hit_idx_next;
      end
    end
  end

  // Operation decode and checks in the order the list defines them.
  always_comb begin
    eff_limit = (cap_limit > CFG_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cap_limit);
    full      = count >= eff_limit;
    key_zero  = (key_r == '0);
    pos_x     = CNT_W'(pos_r);
    pos_key   = slots[pos_r];
    do_app    = 1'b0;
    do_del    = 1'b0;
    do_ins    = 1'b0;
    do_upd    = 1'b0;
    st        = ST_OK;
    fidx      = '0;
    rkey      = '0;
    case (func_r)
      FN_APPEND: begin
        if (key_zero) st = ST_ZERO;
        else if (full) st = ST_FULL;
        else if (hit) st = ST_DUP;
        else begin
          do_app = 1'b1;
          fidx   = count[IDX_W-1:0];
        end
      end
      FN_DELETE: begin
        fidx = pos_r;
        if (pos_x >= count) st = ST_BADIDX;
        else do_del = 1'b1;
      end
      FN_INSERT: begin
        fidx = pos_r;
        if (key_zero) st = ST_ZERO;
        else if (full) st = ST_FULL;
        else if (pos_x > count) st = ST_BADIDX;
        else if (hit) st = ST_DUP;
        else do_ins = 1'b1;
      end
      FN_SEARCH: begin
        if (key_zero) st = ST_ZERO;
        else if (hit) fidx = hit_idx;
        else st = ST_NOTFOUND;
      end
      FN_UPDATE: begin
        fidx = pos_r;
        if (pos_x >= count) st = ST_BADIDX;
        else begin
          rkey = pos_key;
          if (key_zero) st = ST_ZERO;
          else if (hit) st = ST_DUP;
          else do_upd = 1'b1;
        end
      end
      FN_READ: begin
        fidx = pos_r;
        if (pos_x >= count) st = ST_BADIDX;
        else rkey = pos_key;
      end
      default: begin
        st = ST_OK;
      end
    endcase
    count_next = count;
    if (do_app || do_ins) count_next = count + CNT_W'(1);
    else if (do_del) count_next = count - CNT_W'(1);
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // Row of key cells; each loads its own new key, a neighbor's, or zero when freed.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [KEY_WIDTH-1:0] below_key;
    logic [KEY_WIDTH-1:0] above_key;
    logic [CNT_W-1:0]     cell_idx;

    assign cell_idx = CNT_W'(g);

    if (g > 0) begin : g_below
      assign below_key = slots[g-1];
    end else begin : g_no_below
      assign below_key = '0;
    end

    if (g < TABLE_DEPTH - 1) begin : g_above
      assign above_key = slots[g+1];
    end else begin : g_no_above
      assign above_key = '0;
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (do_app && cell_idx == count) begin
          slots[g] <= key_r;
        end else if (do_upd && cell_idx == pos_x) begin
          slots[g] <= key_r;
        end else if (do_del && cell_idx == count - CNT_W'(1)) begin
          slots[g] <= '0;
        end else if (do_del && cell_idx >= pos_x && cell_idx < count) begin
          slots[g] <= above_key;
        end else if (do_ins && cell_idx == pos_x) begin
          slots[g] <= key_r;
        end else if (do_ins && cell_idx > pos_x && cell_idx <= count) begin
          slots[g] <= below_key;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= st;
      found_index  <= fidx;
      read_key     <= rkey;
      entries_used <= count_next;
    end
  end

  // The fill count never passes the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // Unique keys give at most one matching cell.
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("more than one cell matched the key");

  // The count moves by at most one per operation and only when one executes.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(count))
    else $error("fill count changed without an operation");

endmodule

FILE: design/ukat_ctrl.sv
module ukat_ctrl
  import ukat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ukat_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Command decode.
  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.cmp  = (state == S_CMP);
    cmd.find = (state == S_FIND);
    cmd.exec = (state == S_EXEC) && out_free;
  end

  // Sequencer: capture, compare, encode, execute.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_FIND;
      end
      S_FIND: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // An accepted transaction always moves on to the compare step.
  a_load_to_cmp: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CMP)
    else $error("accepted transaction did not start a compare");

  // A result appears only right after an execute step.
  a_out_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.exec))
    else $error("result raised without an execute step");

  // Execute never overwrites a result still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!out_valid || out_ready))
    else $error("result register overwritten while stalled");

endmodule

FILE: design/unique_key_array_table.sv
// Packed list of unique nonzero keys with append, delete, insert, search,
// update and read operations.
//
// Request channel (in_valid/in_ready) carries func, position and key_value;
// a transaction is taken when both are high. Result channel
// (out_valid/out_ready) carries status, found_index, read_key and
// entries_used, one result per request. The configuration channel
// (cfg_valid/cfg_ready) writes capacity_limit and is always ready.
//
// Each request goes through four steps: capture at acceptance, a parallel
// compare in every key cell, an encode of the match vector, and an execute
// step that applies the operation, shifting cells by one place for insert and
// delete, and loads the result register. One request is in flight at a time
// and the request channel is ready again right after the execute step, so a
// new request is taken only once the previous one has executed.
//
// Reset empties the list and sets the capacity to 64. When the receiver
// stalls, the result is held and the execute step of the next request
// waits until the held result is taken.
module unique_key_array_table
  import ukat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     capacity_limit,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    func,
  input  logic [IDX_W-1:0]     position,
  input  logic [KEY_WIDTH-1:0] key_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    status,
  output logic [IDX_W-1:0]     found_index,
  output logic [KEY_WIDTH-1:0] read_key,
  output logic [CNT_W-1:0]     entries_used
);

  ukat_cmd_t cmd;

  assign cfg_ready = 1'b1;

  ukat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ukat_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_value    (capacity_limit),
    .func         (func),
    .position     (position),
    .key_value    (key_value),
    .status       (status),
    .found_index  (found_index),
    .read_key     (read_key),
    .entries_used (entries_used)
  );

endmodule

FILE: test/tb_unique_key_array_table.sv
`timescale 1ns / 1ps

module tb_unique_key_array_table;
  import ukat_pkg::*;

  // Function codes that the block must treat as no-ops.
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD_CYCLES = 300;

  // One expected result transaction.
  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [IDX_W-1:0]     found_index;
    logic [KEY_WIDTH-1:0] read_key;
    logic [CNT_W-1:0]     entries_used;
  } op_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     capacity_limit;
  logic                 in_valid;
  logic                 in_ready;
  logic [FUNC_W-1:0]    func;
  logic [IDX_W-1:0]     position;
  logic [KEY_WIDTH-1:0] key_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [STAT_W-1:0]    status;
  logic [IDX_W-1:0]     found_index;
  logic [KEY_WIDTH-1:0] read_key;
  logic [CNT_W-1:0]     entries_used;

  // Shadow copy of the table and its capacity register.
  logic [KEY_WIDTH-1:0] model_keys [TABLE_DEPTH];
  int                   model_count;
  int                   model_limit;

  op_result_t pending_results [$];
  int         errors;
  int         cycle_count;
  bit         quiet;
  bit         long_hold;

  unique_key_array_table u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .capacity_limit (capacity_limit),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .position       (position),
    .key_value      (key_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_index    (found_index),
    .read_key       (read_key),
    .entries_used   (entries_used)
  );

  always #2 clk = ~clk;

  // Returns the slot that holds the key among the used slots, or -1.
  function automatic int find_key(input logic [KEY_WIDTH-1:0] key);
    for (int i = 0; i < model_count; i++) begin
      if (model_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one operation to the shadow table and returns its result.
  function automatic op_result_t apply_table_op(input logic [FUNC_W-1:0] fn,
                                                input logic [IDX_W-1:0] pos,
                                                input logic [KEY_WIDTH-1:0] key);
    op_result_t r;
    int lim;
    bit full;
    int hit;
    int p;
    r = '0;
    lim = (model_limit > TABLE_DEPTH) ? TABLE_DEPTH : model_limit;
    full = (model_count >= lim);
    hit = find_key(key);
    p = pos;
    case (fn)
      FN_APPEND: begin
        if (key == '0) r.status = ST_ZERO;
        else if (full) r.status = ST_FULL;
        else if (hit >= 0) r.status = ST_DUP;
        else begin
          model_keys[model_count] = key;
          r.found_index = IDX_W'(model_count);
          model_count++;
        end
      end
      FN_DELETE: begin
        r.found_index = pos;
        if (p >= model_count) r.status = ST_BADIDX;
        else begin
          for (int i = p; i + 1 < model_count; i++) model_keys[i] = model_keys[i + 1];
          model_keys[model_count - 1] = '0;
          model_count--;
        end
      end
      FN_INSERT: begin
        r.found_index = pos;
        if (key == '0) r.status = ST_ZERO;
        else if (full) r.status = ST_FULL;
        else if (p > model_count) r.status = ST_BADIDX;
        else if (hit >= 0) r.status = ST_DUP;
        else begin
          for (int i = model_count; i > p; i--) model_keys[i] = model_keys[i - 1];
          model_keys[p] = key;
          model_count++;
        end
      end
      FN_SEARCH: begin
        if (key == '0) r.status = ST_ZERO;
        else if (hit >= 0) r.found_index = IDX_W'(hit);
        else r.status = ST_NOTFOUND;
      end
      FN_UPDATE: begin
        r.found_index = pos;
        if (p >= model_count) r.status = ST_BADIDX;
        else begin
          r.read_key = model_keys[p];
          if (key == '0) r.status = ST_ZERO;
          else if (hit >= 0) r.status = ST_DUP;
          else model_keys[p] = key;
        end
      end
      FN_READ: begin
        r.found_index = pos;
        if (p >= model_count) r.status = ST_BADIDX;
        else r.read_key = model_keys[p];
      end
      default: begin
      end
    endcase
    r.entries_used = CNT_W'(model_count);
    return r;
  endfunction

  // Picks a key: often one already stored, sometimes an edge value or zero.
  function automatic logic [KEY_WIDTH-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && model_count > 0) return model_keys[$urandom_range(0, model_count - 1)];
    if (r < 50) return '0;
    if (r < 53) return '1;
    if (r < 56) return KEY_WIDTH'(1);
    if (r < 58) return {1'b1, {(KEY_WIDTH - 1){1'b0}}};
    return $urandom;
  endfunction

  // Picks an index, mostly near the used part of the table.
  function automatic logic [IDX_W-1:0] pick_position();
    int hi;
    hi = (model_count > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : model_count;
    if ($urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, hi));
    return IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
  endfunction

  // Picks an operation code, leaning toward delete when the table is well filled.
  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (model_count > 40 && $urandom_range(0, 2) == 0) return FN_DELETE;
    if (r < 28) return FN_APPEND;
    if (r < 43) return FN_DELETE;
    if (r < 58) return FN_INSERT;
    if (r < 70) return FN_SEARCH;
    if (r < 82) return FN_UPDATE;
    if (r < 96) return FN_READ;
    if (r < 98) return FN_SPARE_6;
    return FN_SPARE_7;
  endfunction

  // Compare result transactions against the oldest expectation, and track
  // accepted requests and register writes in the shadow table.
  always @(posedge clk) begin : track_dut
    op_result_t want;
    if (!rst) begin
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
          end
          if (found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index, found_index);
            errors++;
          end
          if (read_key !== want.read_key) begin
            $error("read_key: expected %h, actual %h", want.read_key, read_key);
            errors++;
          end
          if (entries_used !== want.entries_used) begin
            $error("entries_used: expected %0d, actual %0d", want.entries_used,
                   entries_used);
            errors++;
          end
        end
      end
      if (in_valid && in_ready === 1'b1) begin
        pending_results.push_back(apply_table_op(func, position, key_value));
      end
      if (cfg_valid && cfg_ready === 1'b1) model_limit = capacity_limit;
    end
  end

  // Result receiver: random stall bursts, ready stretches, and a long hold on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      if (long_hold) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_unique_key_array_table failed");
    $finish;
  end

  // Sends one request transaction, with an occasional idle burst ahead of it.
  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] pos,
                         input logic [KEY_WIDTH-1:0] key);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    func      = fn;
    position  = pos;
    key_value = key;
    in_valid  = 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering requests until every expected result has arrived.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Writes the capacity register while the block is idle.
  task automatic write_limit(input logic [CFG_W-1:0] value);
    drain();
    capacity_limit = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_op(pick_func(), pick_position(), pick_key());
  endtask

  // Field extremes, every operation and each documented corner case.
  task automatic test_directed();
    write_limit(CFG_W'(64));
    send_op(FN_SEARCH, 6'd0, 32'd5);              // search in an empty table
    send_op(FN_READ, 6'd0, 32'd0);                // read beyond the count
    send_op(FN_DELETE, 6'd0, 32'd0);              // delete beyond the count
    send_op(FN_UPDATE, 6'd0, 32'd9);              // update beyond the count
    send_op(FN_APPEND, 6'd0, 32'd0);              // zero key rejected
    send_op(FN_APPEND, 6'd63, 32'hFFFF_FFFF);
    send_op(FN_APPEND, 6'd0, 32'd1);
    send_op(FN_APPEND, 6'd0, 32'hFFFF_FFFF);      // duplicate key
    send_op(FN_INSERT, 6'd2, 32'h8000_0000);      // insert at the end
    send_op(FN_INSERT, 6'd0, 32'h1234_5678);      // insert at the front
    send_op(FN_INSERT, 6'd63, 32'd7);             // insert past the count
    send_op(FN_INSERT, 6'd1, 32'd0);              // zero key on insert
    send_op(FN_INSERT, 6'd1, 32'd1);              // duplicate on insert
    send_op(FN_SEARCH, 6'd0, 32'd1);
    send_op(FN_SEARCH, 6'd0, 32'd0);              // zero key on search
    send_op(FN_UPDATE, 6'd0, 32'h1234_5678);      // update to the same key
    send_op(FN_UPDATE, 6'd1, 32'd0);              // zero key on update
    send_op(FN_UPDATE, 6'd1, 32'h5A5A_5A5A);
    send_op(FN_READ, 6'd3, 32'd0);
    send_op(FN_READ, 6'd63, 32'hFFFF_FFFF);
    send_op(FN_DELETE, 6'd1, 32'd0);              // delete from the middle
    send_op(FN_READ, 6'd3, 32'd0);                // freed top slot is gone
    send_op(FN_SEARCH, 6'd0, 32'h5A5A_5A5A);
    send_op(FN_SPARE_6, 6'd63, 32'hFFFF_FFFF);
    send_op(FN_SPARE_7, 6'd0, 32'd0);
  endtask

  // Capacity at its extremes, and lowered below the current count.
  task automatic test_capacity_edges();
    write_limit(CFG_W'(1));
    send_op(FN_APPEND, 6'd0, 32'hCAFE_0001);      // count already above the limit
    send_op(FN_INSERT, 6'd0, 32'hCAFE_0002);
    for (int i = 0; i < 4; i++) send_op(FN_DELETE, 6'd0, 32'd0);
    send_op(FN_APPEND, 6'd0, 32'hCAFE_0003);
    send_op(FN_APPEND, 6'd0, 32'hCAFE_0004);
    send_op(FN_INSERT, 6'd0, 32'hCAFE_0005);
    write_limit(CFG_W'(2));
    send_op(FN_INSERT, 6'd0, 32'hCAFE_0006);
    send_op(FN_APPEND, 6'd0, 32'hCAFE_0007);
    write_limit(CFG_W'(0));                        // zero limit means always full
    send_op(FN_DELETE, 6'd0, 32'd0);
    send_op(FN_APPEND, 6'd0, 32'hCAFE_0008);
    write_limit(CFG_W'(127));                      // above the depth acts as the depth
    send_op(FN_APPEND, 6'd0, 32'hCAFE_0009);
    test_random(20);
  endtask

  // Fill the whole table, then work on it while full.
  task automatic test_fill();
    write_limit(CFG_W'(64));
    for (int i = 0; i < 70; i++) send_op(FN_APPEND, pick_position(), $urandom);
    send_op(FN_INSERT, 6'd0, $urandom);
    send_op(FN_READ, 6'd63, 32'd0);
    send_op(FN_SEARCH, 6'd0, model_keys[TABLE_DEPTH - 1]);
    send_op(FN_DELETE, 6'd63, 32'd0);
    send_op(FN_INSERT, 6'd63, 32'hFEED_BEEF);
    send_op(FN_UPDATE, 6'd63, 32'h0BAD_F00D);
    test_random(60);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    drain();
    long_hold = 1'b1;
    test_random(40);
    drain();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_no_idle();
    drain();
    quiet = 1'b1;
    test_random(200);
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    capacity_limit = CFG_W'(64);
    in_valid       = 1'b0;
    func           = FN_APPEND;
    position       = '0;
    key_value      = '0;
    errors         = 0;
    quiet          = 1'b0;
    long_hold      = 1'b0;
    model_count    = 0;
    model_limit    = 64;
    for (int i = 0; i < TABLE_DEPTH; i++) model_keys[i] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_capacity_edges();
    test_fill();
    write_limit(CFG_W'(64));
    test_random(200);
    test_backpressure();
    write_limit(CFG_W'(1));
    test_random(100);
    write_limit(CFG_W'(2));
    test_random(100);
    write_limit(CFG_W'($urandom_range(3, 62)));
    test_random(300);
    write_limit(CFG_W'(63));
    test_random(250);
    write_limit(CFG_W'(64));
    test_random(150);
    test_no_idle();

    // Let the last results come back, then settle.
    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_unique_key_array_table passed");
    end else begin
      $display("tb_unique_key_array_table failed");
    end
    $finish;
  end

endmodule
